// ===== rtl/vsm_pkg.sv =====
// ----------------------------------------------------------------------------
// vsm_pkg
// Shared types and exponential tables for the vector softmax block.
// ----------------------------------------------------------------------------
package vsm_pkg;

  localparam int ValueW = 16;
  localparam int ExpW   = 17;
  localparam int SumW   = 23;
  localparam int NumW   = 34;
  localparam int DiffW  = 17;

  localparam logic [DiffW-1:0] ExpCutoff = 17'd4096;

  typedef struct packed {
    logic            done;
    logic [ExpW-1:0] quo;
  } vsm_div_t;

  // exp(-k), Q1.16
  function automatic logic [ExpW-1:0] int_tab(input logic [4:0] k);
    logic [ExpW-1:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd24109;
      5'd2:  v = 17'd8869;
      5'd3:  v = 17'd3263;
      5'd4:  v = 17'd1200;
      5'd5:  v = 17'd442;
      5'd6:  v = 17'd162;
      5'd7:  v = 17'd60;
      5'd8:  v = 17'd22;
      5'd9:  v = 17'd8;
      5'd10: v = 17'd3;
      5'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-h/16), Q1.16 with 1.0 as 65536
  function automatic logic [ExpW-1:0] hi_tab(input logic [3:0] h);
    logic [ExpW-1:0] v;
    case (h)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-l/256)
  function automatic logic [ExpW-1:0] lo_tab(input logic [3:0] l);
    logic [ExpW-1:0] v;
    case (l)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65280;
      4'd2:  v = 17'd65026;
      4'd3:  v = 17'd64772;
      4'd4:  v = 17'd64520;
      4'd5:  v = 17'd64268;
      4'd6:  v = 17'd64018;
      4'd7:  v = 17'd63768;
      4'd8:  v = 17'd63520;
      4'd9:  v = 17'd63272;
      4'd10: v = 17'd63025;
      4'd11: v = 17'd62780;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/vsm_ram.sv =====
// ----------------------------------------------------------------------------
// vsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vsm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/vsm_exp.sv =====
// ----------------------------------------------------------------------------
// vsm_exp
// Table exponential exp(-n/256): one table seed, then two rounded multiplies
// through a single shared multiplier.
// ----------------------------------------------------------------------------
module vsm_exp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [vsm_pkg::DiffW-1:0] n,
  output logic                    done,
  output logic [vsm_pkg::ExpW-1:0] e
);
  import vsm_pkg::*;

  typedef enum logic [2:0] {
    EX_IDLE = 3'b001,
    EX_M1   = 3'b010,
    EX_M2   = 3'b100
  } ex_state_t;

  ex_state_t       st_r;
  logic [ExpW-1:0] e_r;
  logic [3:0]      h_r;
  logic [3:0]      l_r;
  logic            done_r;
  logic [ExpW-1:0] coef;
  logic [32:0]     prod;
  logic [ExpW-1:0] e_nxt;

  assign coef  = (st_r == EX_M1) ? hi_tab(h_r) : lo_tab(l_r);
  assign prod  = 33'(e_r) * 33'(coef) + 33'd32768;
  assign e_nxt = prod[32:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= EX_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        EX_IDLE: begin
          if (start) begin
            e_r  <= (n > ExpCutoff) ? '0 : int_tab(n[12:8]);
            h_r  <= n[7:4];
            l_r  <= n[3:0];
            st_r <= EX_M1;
          end
        end
        EX_M1: begin
          e_r  <= e_nxt;
          st_r <= EX_M2;
        end
        EX_M2: begin
          e_r    <= e_nxt;
          done_r <= 1'b1;
          st_r   <= EX_IDLE;
        end
        default: st_r <= EX_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign e    = e_r;

endmodule

// ===== rtl/vsm_div.sv =====
// ----------------------------------------------------------------------------
// vsm_div
// Restoring radix-2 divider, one quotient bit per cycle, 17 quotient bits.
// Dividend must be below den * 2^17. Zero divisor yields zero.
// ----------------------------------------------------------------------------
module vsm_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [vsm_pkg::NumW-1:0] num,
  input  logic [vsm_pkg::SumW-1:0] den,
  output vsm_pkg::vsm_div_t        res
);
  import vsm_pkg::*;

  logic [SumW:0]   rem_r;
  logic [ExpW-1:0] sh_r;
  logic [SumW-1:0] den_r;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [SumW:0]   trial;
  logic            fits;

  assign trial = {rem_r[SumW-1:0], sh_r[ExpW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= {{(SumW+1-ExpW){1'b0}}, num[NumW-1:ExpW]};
        sh_r   <= num[ExpW-1:0];
        den_r  <= den;
        cnt_r  <= 5'(ExpW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? trial - {1'b0, den_r} : trial;
        sh_r  <= {sh_r[ExpW-2:0], fits};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = (den_r == '0) ? '0 : sh_r;

endmodule

// ===== rtl/vector_softmax.sv =====
// ----------------------------------------------------------------------------
// vector_softmax
// Max-subtracted softmax over a streamed vector of signed Q8.8 elements.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per element, in_is_last on
//   the final one. Up to VECTOR_LEN elements are stored; later ones are
//   dropped and every result of that vector carries out_overflow.
//   Result channel (out_valid/out_ready): one beat per stored element, in
//   input order, out_probability in unsigned Q0.16 saturated at 65535,
//   out_last_result on the final beat.
//   Load: one element per cycle while in_ready is high.
//   After the last beat the block drops in_ready and works through the
//   vector twice: an exponential pass (RAM read, seed from table, two
//   multiplies on one shared multiplier) and a divide pass (RAM read,
//   radix-2 divider with 17 quotient bits against the sum of exponentials).
//   Elements are worked one at a time: each pass starts the next element
//   only after the previous one is done, and the divider is the slower step.
//   Reset clears count, maximum, sum and overflow flag; the value RAM needs
//   no clearing. A stalled receiver holds the output register and the next
//   quotient waits in the divider; in_ready returns after the last beat
//   has been loaded into the output register.
// ----------------------------------------------------------------------------
module vector_softmax #(
  parameter int VECTOR_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_element_value,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_probability,
  output logic        out_last_result,
  output logic        out_overflow
);
  import vsm_pkg::*;

  localparam int AddrW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int CntW  = $clog2(VECTOR_LEN + 1);

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_X_RD  = 8'b0000_0010,
    ST_X_WT  = 8'b0000_0100,
    ST_X_EXP = 8'b0000_1000,
    ST_D_RD  = 8'b0001_0000,
    ST_D_WT  = 8'b0010_0000,
    ST_D_DIV = 8'b0100_0000,
    ST_D_OUT = 8'b1000_0000
  } state_t;

  state_t                   state_r;
  logic [CntW-1:0]          cnt_r;
  logic [CntW-1:0]          idx_r;
  logic signed [ValueW-1:0] max_r;
  logic [SumW-1:0]          total_r;
  logic                     ovf_r;

  logic                     out_valid_r;
  logic [15:0]              out_prob_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic                     in_fire;
  logic                     store_ok;
  logic                     idx_is_last;

  logic [ValueW-1:0]        val_rdata;
  logic [ExpW-1:0]          exp_rdata;

  logic                     exp_start;
  logic [DiffW-1:0]         exp_n;
  logic                     exp_done;
  logic [ExpW-1:0]          exp_e;

  logic                     div_start;
  logic [NumW-1:0]          div_num;
  vsm_div_t                 div_res;

  assign in_ready    = (state_r == ST_LOAD);
  assign in_fire     = in_valid && in_ready;
  assign store_ok    = (cnt_r < CntW'(VECTOR_LEN));
  assign idx_is_last = ((idx_r + CntW'(1)) == cnt_r);

  // element store, written in arrival order
  vsm_ram #(.Width(ValueW), .Depth(VECTOR_LEN)) u_val_ram (
    .clk   (clk),
    .we    (in_fire && store_ok),
    .waddr (cnt_r[AddrW-1:0]),
    .wdata (in_element_value),
    .raddr (idx_r[AddrW-1:0]),
    .rdata (val_rdata)
  );

  // exponentials from the first pass, reread for the divide pass
  vsm_ram #(.Width(ExpW), .Depth(VECTOR_LEN)) u_exp_ram (
    .clk   (clk),
    .we    (exp_done),
    .waddr (idx_r[AddrW-1:0]),
    .wdata (exp_e),
    .raddr (idx_r[AddrW-1:0]),
    .rdata (exp_rdata)
  );

  // max - x, never negative
  assign exp_start = (state_r == ST_X_WT);
  assign exp_n     = DiffW'({max_r[ValueW-1], max_r} - {val_rdata[ValueW-1], val_rdata});

  vsm_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .n     (exp_n),
    .done  (exp_done),
    .e     (exp_e)
  );

  // e * 2^16 plus half the sum, for round-to-nearest
  assign div_start = (state_r == ST_D_WT);
  assign div_num   = {1'b0, exp_rdata, 16'd0} + NumW'(total_r[SumW-1:1]);

  vsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (total_r),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      max_r       <= 16'sh8000;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output beat once taken
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (store_ok) begin
              cnt_r <= cnt_r + CntW'(1);
              if ($signed(in_element_value) > max_r) begin
                max_r <= $signed(in_element_value);
              end
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_is_last) begin
              idx_r   <= '0;
              total_r <= '0;
              // an empty vector has nothing to emit
              if (cnt_r == '0 && !store_ok) begin
                cnt_r <= '0;
                max_r <= 16'sh8000;
                ovf_r <= 1'b0;
              end else begin
                state_r <= ST_X_RD;
              end
            end
          end
        end
        ST_X_RD: state_r <= ST_X_WT;
        ST_X_WT: state_r <= ST_X_EXP;
        ST_X_EXP: begin
          if (exp_done) begin
            total_r <= total_r + SumW'(exp_e);
            if (idx_is_last) begin
              idx_r   <= '0;
              state_r <= ST_D_RD;
            end else begin
              idx_r   <= idx_r + CntW'(1);
              state_r <= ST_X_RD;
            end
          end
        end
        ST_D_RD: state_r <= ST_D_WT;
        ST_D_WT: state_r <= ST_D_DIV;
        ST_D_DIV: begin
          if (div_res.done) begin
            state_r <= ST_D_OUT;
          end
        end
        ST_D_OUT: begin
          // hold the quotient until the output register is free
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_prob_r  <= div_res.quo[ExpW-1] ? 16'hFFFF : div_res.quo[15:0];
            out_last_r  <= idx_is_last;
            out_ovf_r   <= ovf_r;
            if (idx_is_last) begin
              cnt_r   <= '0;
              idx_r   <= '0;
              max_r   <= 16'sh8000;
              total_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              idx_r   <= idx_r + CntW'(1);
              state_r <= ST_D_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_last_result = out_last_r;
  assign out_overflow    = out_ovf_r;

  // the element count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(VECTOR_LEN))
    else $error("element count beyond store depth");

  // an exponential only completes while the sequencer waits for it
  a_exp_state: assert property (@(posedge clk) disable iff (!rst_n)
    exp_done |-> state_r == ST_X_EXP)
    else $error("exponential finished outside its wait state");

  // a quotient only completes while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_D_DIV)
    else $error("divider finished outside its wait state");

  // no new element is taken while results of a vector are still being built
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (idx_r == '0 && total_r == '0))
    else $error("load phase entered with pass state left over");

endmodule

// ===== bench/vector_softmax_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_softmax_checker
// Watches both channels of the softmax block, rebuilds each vector from the
// accepted input beats, predicts its probabilities and compares every result
// beat in order.
// ----------------------------------------------------------------------------
module vector_softmax_checker #(
  parameter int VECTOR_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_element_value,
  input  logic        in_is_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_probability,
  input  logic        out_last_result,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [15:0] prob;
    logic        last;
    logic        ovf;
  } prob_beat_t;

  localparam logic [31:0] IntTab[17] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
    60, 22, 8, 3, 1, 0, 0, 0, 0, 0};
  localparam logic [31:0] HiTab[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
    45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
  localparam logic [31:0] LoTab[16] = '{65536, 65280, 65026, 64772, 64520, 64268,
    64018, 63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

  logic signed [15:0] held_vals[VECTOR_LEN];
  int                 held_cnt;
  logic signed [15:0] vec_max;
  logic               dropped;
  prob_beat_t         expected_probs[$];

  assign pending_count = expected_probs.size();

  function automatic logic [31:0] neg_exp(input logic [31:0] n);
    logic [63:0] e;
    if (n > 4096) return 0;
    e = IntTab[n[12:8]];
    e = (e * HiTab[n[7:4]] + 32768) >> 16;
    e = (e * LoTab[n[3:0]] + 32768) >> 16;
    return e[31:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Build the probability beats of the finished vector and clear for the next.
  task automatic close_vector();
    logic [31:0] exps[VECTOR_LEN];
    logic [22:0] total;
    logic [63:0] p;
    prob_beat_t  b;
    total = 0;
    for (int i = 0; i < held_cnt; i++) begin
      exps[i] = neg_exp(32'(int'(vec_max) - int'(held_vals[i])));
      total = total + exps[i][22:0];
    end
    for (int i = 0; i < held_cnt; i++) begin
      p = 0;
      if (total != 0) begin
        p = (64'(exps[i]) * 65536 + (total >> 1)) / total;
        if (p > 65535) p = 65535;
      end
      b.prob = p[15:0];
      b.last = (i + 1 == held_cnt);
      b.ovf  = dropped;
      expected_probs.push_back(b);
    end
    held_cnt = 0;
    vec_max  = -16'sd32768;
    dropped  = 0;
  endtask

  initial begin
    fail_count = 0;
    held_cnt   = 0;
    vec_max    = -16'sd32768;
    dropped    = 0;
  end

  always @(posedge clk) begin
    prob_beat_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_probs.size() == 0) begin
          report_mismatch("unexpected result beat", out_probability, -1);
        end else begin
          w = expected_probs.pop_front();
          if (out_probability !== w.prob) report_mismatch("probability", out_probability, w.prob);
          if (out_last_result !== w.last) report_mismatch("last_result", out_last_result, w.last);
          if (out_overflow !== w.ovf) report_mismatch("overflow", out_overflow, w.ovf);
        end
      end
      if (in_valid && in_ready) begin
        if (held_cnt < VECTOR_LEN) begin
          held_vals[held_cnt] = in_element_value;
          held_cnt++;
          if ($signed(in_element_value) > vec_max) vec_max = in_element_value;
        end else begin
          dropped = 1;
        end
        if (in_is_last) close_vector();
      end
    end
  end

endmodule

// ===== bench/vector_softmax_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_softmax_tb
// Streams directed and random vectors into the softmax block under random
// idling on both sides; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module vector_softmax_tb;

  localparam int VectorLen = 64;
  localparam int CycleLimit = 1500000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_element_value;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_probability;
  logic        out_last_result;
  logic        out_overflow;
  int          fail_count;
  int          pending_count;
  int          cycle_count;
  bit          calm;  // when set, neither side idles

  vector_softmax #(.VECTOR_LEN(VectorLen)) u_dut (.*);

  vector_softmax_checker #(.VECTOR_LEN(VectorLen)) u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_element_value, .in_is_last,
    .out_valid, .out_ready, .out_probability, .out_last_result, .out_overflow,
    .fail_count, .pending_count
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall about 36 percent of the time, except in the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 36);
  end

  // Send one beat: optionally idle first, then hold valid until accepted.
  // Valid stays up after the accepting edge; the next call either idles or
  // replaces the payload at this same falling edge.
  task automatic send_beat(input logic [15:0] v, input logic last);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid         <= 1;
    in_element_value <= v;
    in_is_last       <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random element: mostly near a shared center so exponentials are not all
  // zero, sometimes anywhere in the range.
  function automatic logic [15:0] pick_value(input int center);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(center + int'($urandom_range(4400)) - 2200);
  endfunction

  task automatic send_vector(input int len, input int center);
    for (int i = 0; i < len; i++) send_beat(pick_value(center), i == len - 1);
  endtask

  initial begin
    int len;
    int sent;
    cycle_count      = 0;
    calm             = 0;
    rst_n            = 0;
    in_valid         = 0;
    in_element_value = 0;
    in_is_last       = 0;
    out_ready        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: single elements, two of them at the extremes, saturate to 65535.
    send_beat(16'h7fff, 1);
    send_beat(16'h8000, 1);
    send_beat(16'h0000, 1);
    // Difference of exactly -16.0 and just beyond it.
    send_beat(16'h1000, 0);
    send_beat(16'h0000, 0);
    send_beat(16'h0fff, 0);
    send_beat(16'hffff, 1);
    // Extremes together: the most negative gives zero.
    send_beat(16'h8000, 0);
    send_beat(16'h7fff, 0);
    send_beat(16'h5555, 0);
    send_beat(16'haaaa, 1);
    // Equal elements.
    repeat (3) send_beat(16'h0100, 0);
    send_beat(16'h0100, 1);
    sent = 15;

    // Full store plus dropped beats, the last one dropped too.
    for (int i = 0; i < VectorLen + 3; i++)
      send_beat(16'(i * 37 - 1000), i == VectorLen + 2);
    sent += VectorLen + 3;

    // Random vectors: mostly short, an occasional full or overflowing one,
    // with a calm stretch in the middle.
    while (sent < 410) begin
      calm = (sent > 180 && sent < 260);
      case ($urandom_range(9))
        0:       len = VectorLen + $urandom_range(4);
        1:       len = $urandom_range(VectorLen, 20);
        default: len = $urandom_range(8, 1);
      endcase
      send_vector(len, int'($urandom_range(65535)) - 32768);
      sent += len;
    end
    calm = 0;
    in_valid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vsm_pkg.sv
rtl/vsm_ram.sv
rtl/vsm_exp.sv
rtl/vsm_div.sv
rtl/vector_softmax.sv
bench/vector_softmax_checker.sv
bench/vector_softmax_tb.sv
